>>> src/contingency_phi_squared_2x2_unit_macros.svh
// Assertion macros for the 2x2 contingency phi-squared unit.
// Used by the top level only; needs a clock named aclk and a reset named aresetn.
`ifndef CONTINGENCY_PHI_SQUARED_2X2_UNIT_MACROS_SVH
`define CONTINGENCY_PHI_SQUARED_2X2_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle, outside reset.
`define CPHI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds at every clock edge outside reset.
`define CPHI_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

`endif

>>> src/cphi_pkg.sv
// Package for the 2x2 contingency phi-squared unit.
// Holds the fraction width and the per-item status flags; no dependencies.
package cphi_pkg;

    localparam int FRAC_BITS = 31;

    typedef struct packed {
        logic invalid;   // impossible table
        logic zero_cell; // an expected count is zero, result is 0
        logic sat;       // numerator reaches denominator, result is 1.0
    } cphi_flags_t;

endpackage

>>> src/contingency_phi_squared_2x2_unit.sv
// Phi-squared of a 2x2 contingency table, unsigned Q1.31, truncated.
// Four arithmetic stages, 32 divider stages and one output register.
// Throughput one item per cycle; the whole pipeline halts only while a result waits.
// The slowest step is one quotient bit of the restoring divider, one per stage.
// Reset (aresetn, synchronous, active low) clears all valid bits; data is not cleared.
// Depends on cphi_pkg, cphi_divider and the assertion macro header.
`include "contingency_phi_squared_2x2_unit_macros.svh"

module contingency_phi_squared_2x2_unit
    import cphi_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COUNT_BITS-1:0] s_pos_inside,
    input  logic [COUNT_BITS-1:0] s_neg_inside,
    input  logic [COUNT_BITS-1:0] s_pos_total,
    input  logic [COUNT_BITS-1:0] s_neg_total,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [31:0]           m_phi_squared,
    output logic                  m_invalid
);

    localparam int C     = COUNT_BITS;
    localparam int W1    = C + 1;
    localparam int W2    = 2 * C;
    localparam int WS    = 2 * C + 2;     // s * rest
    localparam int WP    = 2 * C + 1;     // partial products of the denominator
    localparam int NUM_W = 4 * C;
    localparam int DEN_W = 4 * C + 2;

    logic enable;
    assign enable  = !m_valid || m_ready;
    assign s_ready = enable;

    // Stage 1: cross products, marginal products and the table checks.
    logic [W2-1:0]  a_next, b_next, tn_next;
    logic [WS-1:0]  sr_next;
    logic [W1-1:0]  t_sum, s_sum, rest_sum;
    cphi_flags_t    f1_next;
    logic [W2-1:0]  a_reg, b_reg, tn1_reg;
    logic [WS-1:0]  sr1_reg;
    cphi_flags_t    f1_reg;
    logic           v1_reg;

    always_comb begin
        t_sum    = W1'(s_pos_total) + W1'(s_neg_total);
        s_sum    = W1'(s_pos_inside) + W1'(s_neg_inside);
        rest_sum = W1'(s_pos_total - s_pos_inside) + W1'(s_neg_total - s_neg_inside);
        a_next   = W2'(s_pos_inside) * W2'(s_neg_total);
        b_next   = W2'(s_neg_inside) * W2'(s_pos_total);
        tn_next  = W2'(s_pos_total) * W2'(s_neg_total);
        sr_next  = WS'(s_sum) * WS'(rest_sum);
        f1_next.invalid   = (t_sum == '0) || (s_pos_inside > s_pos_total)
                          || (s_neg_inside > s_neg_total);
        f1_next.zero_cell = (s_sum == '0) || (rest_sum == '0)
                          || (s_pos_total == '0) || (s_neg_total == '0);
        f1_next.sat       = 1'b0;
    end

    // Stage 2: absolute difference of the cross products.
    logic [W2-1:0] d_next;
    logic [W2-1:0] d2_reg, tn2_reg;
    logic [WS-1:0] sr2_reg;
    cphi_flags_t   f2_reg;
    logic          v2_reg;

    assign d_next = (a_reg > b_reg) ? (a_reg - b_reg) : (b_reg - a_reg);

    // Stage 3: partial products of d * d and (s * rest) * (pt * nt).
    logic [C-1:0]  dl, dh, tl, th;
    logic [W1-1:0] sl, sh;
    logic [W2-1:0] n_ll_next, n_lh_next, n_hh_next;
    logic [WP-1:0] m_ll_next, m_lh_next, m_hl_next, m_hh_next;
    logic [W2-1:0] n_ll_reg, n_lh_reg, n_hh_reg;
    logic [WP-1:0] m_ll_reg, m_lh_reg, m_hl_reg, m_hh_reg;
    cphi_flags_t   f3_reg;
    logic          v3_reg;

    always_comb begin
        dl = d2_reg[C-1:0];
        dh = d2_reg[W2-1:C];
        sl = sr2_reg[W1-1:0];
        sh = sr2_reg[WS-1:W1];
        tl = tn2_reg[C-1:0];
        th = tn2_reg[W2-1:C];
        n_ll_next = W2'(dl) * W2'(dl);
        n_lh_next = W2'(dl) * W2'(dh);
        n_hh_next = W2'(dh) * W2'(dh);
        m_ll_next = WP'(sl) * WP'(tl);
        m_lh_next = WP'(sl) * WP'(th);
        m_hl_next = WP'(sh) * WP'(tl);
        m_hh_next = WP'(sh) * WP'(th);
    end

    // Stage 4: sum the partial products.
    logic [NUM_W-1:0] num_next, num_reg;
    logic [DEN_W-1:0] den_next, den_reg;
    cphi_flags_t      f4_reg;
    logic             v4_reg;

    always_comb begin
        num_next = (NUM_W'(n_hh_reg) << W2) + (NUM_W'(n_lh_reg) << (C + 1))
                 + NUM_W'(n_ll_reg);
        den_next = (DEN_W'(m_hh_reg) << (2 * C + 1)) + (DEN_W'(m_hl_reg) << W1)
                 + (DEN_W'(m_lh_reg) << C) + DEN_W'(m_ll_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (enable) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
        if (enable) begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            tn1_reg  <= tn_next;
            sr1_reg  <= sr_next;
            f1_reg   <= f1_next;
            d2_reg   <= d_next;
            tn2_reg  <= tn1_reg;
            sr2_reg  <= sr1_reg;
            f2_reg   <= f1_reg;
            n_ll_reg <= n_ll_next;
            n_lh_reg <= n_lh_next;
            n_hh_reg <= n_hh_next;
            m_ll_reg <= m_ll_next;
            m_lh_reg <= m_lh_next;
            m_hl_reg <= m_hl_next;
            m_hh_reg <= m_hh_next;
            f3_reg   <= f2_reg;
            num_reg  <= num_next;
            den_reg  <= den_next;
            f4_reg   <= f3_reg;
        end
    end

    logic                 div_valid;
    logic [FRAC_BITS-1:0] div_q;
    cphi_flags_t          div_flags;

    cphi_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (enable),
        .in_valid  (v4_reg),
        .num       (num_reg),
        .den       (den_reg),
        .in_flags  (f4_reg),
        .out_valid (div_valid),
        .quotient  (div_q),
        .out_flags (div_flags)
    );

    // Output register: impossible and degenerate tables give 0, saturation gives 1.0.
    logic [31:0] phi_next, phi_reg;
    logic        inv_reg, out_valid_reg;

    always_comb begin
        if (div_flags.invalid || div_flags.zero_cell) begin
            phi_next = '0;
        end else if (div_flags.sat) begin
            phi_next = 32'h8000_0000;
        end else begin
            phi_next = {1'b0, div_q};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (enable) begin
            out_valid_reg <= div_valid;
        end
        if (enable) begin
            phi_reg <= phi_next;
            inv_reg <= div_flags.invalid;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_phi_squared = phi_reg;
    assign m_invalid     = inv_reg;

    `CPHI_ASSERT_IMPL(a_invalid_zero, m_valid && m_invalid, m_phi_squared == 32'h0, "bad invalid")
    `CPHI_ASSERT_IMPL(a_phi_range, m_valid, m_phi_squared <= 32'h8000_0000, "above 1.0")
    `CPHI_ASSERT_ALWAYS(a_ready_rule, s_ready == (!m_valid || m_ready), "ready rule")

endmodule

>>> src/cphi_divider.sv
// Pipelined restoring divider: one quotient bit per stage, FRAC_BITS + 1 stages.
// Depends on cphi_pkg for the fraction width and the status flags.
module cphi_divider
    import cphi_pkg::*;
#(
    parameter int NUM_W = 96,
    parameter int DEN_W = 98
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 enable,
    input  logic                 in_valid,
    input  logic [NUM_W-1:0]     num,
    input  logic [DEN_W-1:0]     den,
    input  cphi_flags_t          in_flags,
    output logic                 out_valid,
    output logic [FRAC_BITS-1:0] quotient,
    output cphi_flags_t          out_flags
);

    localparam int REM_W = DEN_W + 1;

    logic [REM_W-1:0]     rem_reg   [0:FRAC_BITS];
    logic [DEN_W-1:0]     den_reg   [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] q_reg     [0:FRAC_BITS];
    cphi_flags_t          flags_reg [0:FRAC_BITS];
    logic                 valid_reg [0:FRAC_BITS];
    cphi_flags_t          entry_flags;

    always_comb begin
        entry_flags     = in_flags;
        entry_flags.sat = (REM_W'(num) >= REM_W'(den));
    end

    // Entry stage: the saturation test; for an unsaturated item the remainder then stays below den.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (enable) begin
            valid_reg[0] <= in_valid;
        end
        if (enable) begin
            rem_reg[0]   <= REM_W'(num);
            den_reg[0]   <= den;
            q_reg[0]     <= '0;
            flags_reg[0] <= entry_flags;
        end
    end

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_stage
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] den_ext;
        logic             take;

        always_comb begin
            shifted = {rem_reg[k-1][REM_W-2:0], 1'b0};
            den_ext = {1'b0, den_reg[k-1]};
            take    = (shifted >= den_ext);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (enable) begin
                valid_reg[k] <= valid_reg[k-1];
            end
            if (enable) begin
                rem_reg[k]   <= take ? (shifted - den_ext) : shifted;
                den_reg[k]   <= den_reg[k-1];
                q_reg[k]     <= {q_reg[k-1][FRAC_BITS-2:0], take};
                flags_reg[k] <= flags_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[FRAC_BITS];
    assign quotient  = q_reg[FRAC_BITS];
    assign out_flags = flags_reg[FRAC_BITS];

endmodule

>>> bench/contingency_phi_squared_2x2_unit_test.sv
// Self-checking bench for the 2x2 contingency phi-squared unit.
// Drives tables over valid/ready, predicts phi-squared exactly and compares each item.
// Depends on contingency_phi_squared_2x2_unit and cphi_pkg only.
`timescale 1ns / 1ps

module contingency_phi_squared_2x2_unit_test
    import cphi_pkg::*;
();

    localparam int CB = 24;
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [31:0] NO_EXP = 32'hFFFF_FFFF;

    typedef struct {
        logic [CB-1:0] p, n, pt, nt;
    } table_t;

    typedef struct {
        logic [31:0] phi;
        logic        inv;
    } score_t;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready, m_invalid;
    logic [CB-1:0] s_pos_inside, s_neg_inside, s_pos_total, s_neg_total;
    logic [31:0] m_phi_squared;

    score_t pending_scores[$];
    int errors = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    contingency_phi_squared_2x2_unit #(.COUNT_BITS(CB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_inside(s_pos_inside), .s_neg_inside(s_neg_inside),
        .s_pos_total(s_pos_total), .s_neg_total(s_neg_total),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_phi_squared(m_phi_squared), .m_invalid(m_invalid)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic score_t phi_squared_of(table_t tb);
        logic [24:0] t, s, rest;
        logic [47:0] a, b, d;
        logic [159:0] num, den;
        score_t r;
        t = tb.pt + tb.nt;
        r.phi = 0;
        r.inv = 0;
        if (t == 0 || tb.p > tb.pt || tb.n > tb.nt) begin
            r.inv = 1;
            return r;
        end
        s = tb.p + tb.n;
        rest = t - s;
        if (s == 0 || rest == 0 || tb.pt == 0 || tb.nt == 0) return r;
        a = tb.p * tb.nt;
        b = tb.n * tb.pt;
        d = (a > b) ? a - b : b - a;
        num = d * d;
        den = s * rest * tb.pt * tb.nt;
        if (num >= den) r.phi = ONE_Q31;
        else r.phi = 32'((num << FRAC_BITS) / den);
        return r;
    endfunction

    // Receiver side: random back-pressure and the comparison of each item.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_scores.size() == 0) begin
                    $display("%0t: unexpected item phi=%h invalid=%b", $time,
                             m_phi_squared, m_invalid);
                    errors++;
                end else begin
                    score_t e;
                    e = pending_scores.pop_front();
                    if (e.phi !== m_phi_squared || e.inv !== m_invalid) begin
                        $display("%0t: expected phi=%h invalid=%b, got phi=%h invalid=%b",
                                 $time, e.phi, e.inv, m_phi_squared, m_invalid);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_table(table_t tb, score_t typed);
        score_t e;
        e = phi_squared_of(tb);
        // Rows with a typed result check the predictor too.
        if (typed.phi !== NO_EXP && (typed.phi !== e.phi || typed.inv !== e.inv)) begin
            $display("%0t: expected phi=%h invalid=%b, predictor gave phi=%h invalid=%b",
                     $time, typed.phi, typed.inv, e.phi, e.inv);
            errors++;
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_pos_inside <= tb.p;
        s_neg_inside <= tb.n;
        s_pos_total <= tb.pt;
        s_neg_total <= tb.nt;
        do @(posedge aclk); while (!s_ready);
        pending_scores.push_back(e);
    endtask

    function automatic logic [CB-1:0] rand_count();
        case ($urandom_range(3))
            0: return CB'($urandom_range(20));
            1: return CB'($urandom);
            2: return {CB{1'b1}} - CB'($urandom_range(3));
            default: return CB'($urandom_range(4095));
        endcase
    endfunction

    function automatic table_t rand_table();
        table_t tb;
        tb.pt = rand_count();
        tb.nt = rand_count();
        tb.p = rand_count();
        tb.n = rand_count();
        // Mostly well-formed tables; the rest may be impossible.
        if ($urandom_range(9) != 0) begin
            if (tb.p > tb.pt) tb.p = (tb.pt == 0) ? 0 : CB'($urandom_range(tb.pt));
            if (tb.n > tb.nt) tb.n = (tb.nt == 0) ? 0 : CB'($urandom_range(tb.nt));
        end
        return tb;
    endfunction

    localparam logic [CB-1:0] MX = {CB{1'b1}};
    localparam int N_DIR = 14;
    table_t dir_tables[N_DIR] = '{
        '{0, 0, 0, 0}, '{1, 0, 0, 1}, '{0, 1, 1, 0}, '{MX, MX, MX, MX},
        '{MX, 0, MX, MX}, '{0, MX, MX, MX}, '{1, 0, 1, 1}, '{3, 2, 5, 2},
        '{0, 0, 7, 9}, '{5, 0, 5, 0}, '{2, 3, 4, 9}, '{MX, 1, MX, MX},
        '{123, 456, 789, 1011}, '{1, 1, MX, MX}
    };
    score_t dir_scores[N_DIR] = '{
        '{0, 1}, '{0, 1}, '{0, 1}, '{0, 0}, '{ONE_Q31, 0}, '{ONE_Q31, 0},
        '{ONE_Q31, 0}, '{NO_EXP, 0}, '{0, 0}, '{0, 0}, '{NO_EXP, 0},
        '{NO_EXP, 0}, '{NO_EXP, 0}, '{NO_EXP, 0}
    };

    initial begin
        int wait_cycles;
        aresetn = 0;
        s_valid = 0;
        s_pos_inside = 0;
        s_neg_inside = 0;
        s_pos_total = 0;
        s_neg_total = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        for (int i = 0; i < N_DIR; i++) send_table(dir_tables[i], dir_scores[i]);
        for (int ph = 0; ph < 5; ph++) begin
            tx_idle_pct = (ph == 1 || ph == 4) ? 85 : (ph == 3 ? 11 : 0);
            rx_stall_pct = (ph == 2 || ph == 4) ? 85 : (ph == 3 ? 11 : 0);
            for (int i = 0; i < 250; i++) send_table(rand_table(), '{NO_EXP, 0});
        end
        s_valid <= 0;
        wait_cycles = 0;
        while (pending_scores.size() != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (60) @(posedge aclk);
        if (errors == 0 && pending_scores.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
